>>> rtl/core/assert_macros.svh
// Assertion helpers. Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PLB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define PLB_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define PLB_ASSERT(lbl, clk, rstn, prop, msg)
`define PLB_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/core/plb_pkg.sv
package plb_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;  // open a slot at pos, later entries move back
    logic             del;  // close the slot at pos, later entries move up
    logic             rd;   // drive the entry at pos onto the tap
    logic [POS_W-1:0] pos;
  } shift_ctrl_t;

endpackage

>>> rtl/core/plb_cell.sv
module plb_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CMP_W = 7
) (
  input  logic                                clk_i,
  input  plb_pkg::shift_ctrl_t                ctrl_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   value_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   left_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   right_i,
  output logic signed [plb_pkg::WORD_W-1:0]   entry_o,
  output logic signed [plb_pkg::WORD_W-1:0]   tap_o
);
  import plb_pkg::*;

  localparam logic [CMP_W-1:0] Idx = CMP_W'(INDEX);

  logic signed [WORD_W-1:0] entry_d, entry_q;
  logic [CMP_W-1:0]         pos_w;

  assign pos_w = CMP_W'(ctrl_i.pos);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (Idx == pos_w) begin
        entry_d = value_i;
      end else if (Idx > pos_w) begin
        entry_d = left_i;
      end
    end
    if (ctrl_i.del && (Idx >= pos_w)) begin
      entry_d = right_i;
    end
  end

  // list contents carry no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = (ctrl_i.rd && (Idx == pos_w)) ? entry_q : '0;

endmodule

>>> rtl/core/positional_list_buffer.sv
// Channel   Handshake          Payload
// request   start_i / busy_o   opcode_i, position_i, value_i
// result    done_o (strobe)    status_o, data_out_o, entry_count_o
//
// One item is taken per clock; busy_o stays low, so start_i alone admits it.
// The result strobes on done_o in the cycle after the item, for one cycle.
// The row of DEPTH cells moves all shifted entries on the same edge; checks and the tap
// select on position set the combinational path between registers.
// rst_ni clears the count, done_o and status_o; cell contents stay undefined until written.
// The receiver cannot stall: each result is gone after its strobe cycle.
`include "assert_macros.svh"

module positional_list_buffer #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          opcode_i,
  input  logic [plb_pkg::POS_W-1:0]           position_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   value_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic signed [plb_pkg::WORD_W-1:0]   data_out_o,
  output logic [plb_pkg::COUNT_W-1:0]         entry_count_o
);
  import plb_pkg::*;

  // count needs to hold DEPTH itself; compares run at the wider of count and position
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic                     accept;
  op_e                      op;
  logic [CntW-1:0]          count_d, count_q;
  logic [CmpW-1:0]          pos_w, count_w;
  status_e                  status_d, status_q;
  shift_ctrl_t              ctrl;
  logic signed [WORD_W-1:0] entries [DEPTH];
  logic signed [WORD_W-1:0] taps    [DEPTH];
  logic signed [WORD_W-1:0] tap_or;
  logic signed [WORD_W-1:0] data_q;
  logic                     done_q;

  // never stalls the requester
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign op      = op_e'(opcode_i);
  assign pos_w   = CmpW'(position_i);
  assign count_w = CmpW'(count_q);

  // Range checks and row control. Errors leave the row and count alone.
  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    ctrl     = '0;
    ctrl.pos = position_i;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (count_q == CntW'(DEPTH)) begin
            status_d = ST_FULL;
          end else if (pos_w > count_w) begin
            status_d = ST_BADPOS;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        OP_DELETE, OP_READ: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (pos_w >= count_w) begin
            status_d = ST_BADPOS;
          end else begin
            ctrl.rd = 1'b1;
            if (op == OP_DELETE) begin
              ctrl.del = 1'b1;
              count_d  = count_q - 1'b1;
            end
          end
        end
        default: begin
          // unused opcode: no change, status ok
        end
      endcase
    end
  end

  // Row of cells: on insert each cell past the position takes from its left neighbor and
  // the cell at it takes value_i; on delete each cell from the position on takes from its right neighbor.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entries[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = entries[k+1];
    end

    plb_cell #(
      .INDEX (k),
      .CMP_W (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries[k]),
      .tap_o   (taps[k])
    );
  end

  // at most one tap is nonzero; zero when nothing is read
  always_comb begin
    tap_or = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | taps[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= tap_or;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_out_o    = data_q;
  assign entry_count_o = COUNT_W'(count_q);

  `PLB_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(DEPTH), "count above DEPTH")
  `PLB_ASSERT(a_done_follows, clk_i, rst_ni, accept |=> done_o, "item without result")
  `PLB_ASSERT(a_err_keeps, clk_i, rst_ni,
    (done_o && (status_q != ST_OK)) |-> ((count_q == $past(count_q)) && (data_out_o == '0)),
    "error changed the list or returned data")
  `PLB_ASSERT(a_idle_keeps, clk_i, rst_ni, !accept |=> $stable(count_q),
    "count moved without an item")

endmodule

>>> sim/positional_list_buffer_chk.sv
`timescale 1ns / 1ps

module positional_list_buffer_chk #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [1:0]                          opcode_i,
  input  logic [plb_pkg::POS_W-1:0]           position_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   value_i,
  input  logic                                done_i,
  input  logic [1:0]                          status_i,
  input  logic signed [plb_pkg::WORD_W-1:0]   data_out_i,
  input  logic [plb_pkg::COUNT_W-1:0]         entry_count_i,
  output int                                  mismatches_o,
  output int                                  outstanding_o
);
  import plb_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic [WORD_W-1:0] shadow_list [DEPTH];
  int unsigned       shadow_len;
  list_result_t      awaited_q [$];

  // Applies one request to the shadow list and returns what the block owes.
  function automatic list_result_t apply_request(input logic [1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [WORD_W-1:0] val);
    list_result_t res;
    int unsigned  p;
    p          = int'(pos);
    res.status = ST_OK;
    res.data   = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else if (p > shadow_len) begin
          res.status = ST_BADPOS;
        end else begin
          for (int unsigned i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_len++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p >= shadow_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.data = shadow_list[p];
          if (op == OP_DELETE) begin
            for (int unsigned i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            shadow_len--;
          end
        end
      end
      default: ;  // unused opcode: no change, count echoed
    endcase
    res.count = COUNT_W'(shadow_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    int           errs;
    errs = 0;
    if (!rst_ni) begin
      shadow_len = 0;
      awaited_q.delete();
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      // result strobe belongs to an earlier item, so check before queuing
      if (done_i) begin
        if (awaited_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          errs++;
        end else begin
          want = awaited_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errs++;
          end
          if (data_out_i !== want.data) begin
            $error("data_out: expected %0d, got %0d", $signed(want.data), data_out_i);
            errs++;
          end
          if (entry_count_i !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count_i);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) awaited_q.push_back(apply_request(opcode_i, position_i, value_i));
      mismatches_o  <= mismatches_o + errs;
      outstanding_o <= awaited_q.size();
    end
  end

endmodule

>>> sim/positional_list_buffer_tb.sv
`timescale 1ns / 1ps

module positional_list_buffer_tb;
  import plb_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;  // no package name; block ignores it
  localparam int          RAND_ITEMS = 1250;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      start_i       = 1'b0;
  logic [1:0]                opcode_i      = OP_INSERT;
  logic [POS_W-1:0]          position_i    = '0;
  logic signed [WORD_W-1:0]  value_i       = '0;
  logic                      busy_o;
  logic                      done_o;
  logic [1:0]                status_o;
  logic signed [WORD_W-1:0]  data_out_o;
  logic [COUNT_W-1:0]        entry_count_o;

  int   mismatches;
  int   outstanding;
  int   list_len;     // entries held, tracked only to aim positions
  logic idle_en;

  positional_list_buffer #(.DEPTH(LIST_DEPTH)) uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .position_i, .value_i,
    .done_o, .status_o, .data_out_o, .entry_count_o
  );

  positional_list_buffer_chk #(.DEPTH(LIST_DEPTH)) chk (
    .clk_i, .rst_ni, .start_i,
    .busy_i        (busy_o),
    .opcode_i, .position_i, .value_i,
    .done_i        (done_o),
    .status_i      (status_o),
    .data_out_i    (data_out_o),
    .entry_count_i (entry_count_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #200_000;
    $display("[positional_list_buffer] ERROR");
    $finish;
  end

  // Random idle cycles ahead of an item; payload carries junk while start is low.
  task automatic idle_gaps();
    while (idle_en && $urandom_range(99) < 32) begin
      start_i    <= 1'b0;
      opcode_i   <= 2'($urandom);
      position_i <= POS_W'($urandom);
      value_i    <= $urandom;
      @(posedge clk_i);
    end
  endtask

  // Present one item and hold it until the block takes it.
  task automatic issue(input logic [1:0] op, input logic [POS_W-1:0] pos,
                       input logic [WORD_W-1:0] val);
    idle_gaps();
    start_i    <= 1'b1;
    opcode_i   <= op;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // keep the length guess in step so random positions land in range
    if (op == OP_INSERT && list_len < LIST_DEPTH && int'(pos) <= list_len) list_len++;
    if (op == OP_DELETE && list_len > 0 && int'(pos) < list_len) list_len--;
  endtask

  // Opcode mix leans toward growing or shrinking the list.
  function automatic logic [1:0] pick_op(input logic grow);
    int r;
    r = $urandom_range(99);
    if (r < 3) return OP_UNUSED;
    if (grow) return (r < 65) ? OP_INSERT : (r < 85) ? OP_DELETE : OP_READ;
    return (r < 30) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_READ;
  endfunction

  // Mostly a legal position; now and then anything the field can hold.
  function automatic logic [POS_W-1:0] pick_pos(input logic [1:0] op);
    if ($urandom_range(99) < 12) return POS_W'($urandom_range(127));
    if (op == OP_INSERT) return POS_W'($urandom_range(list_len));
    if (list_len == 0) return POS_W'($urandom_range(127));
    return POS_W'($urandom_range(list_len - 1));
  endfunction

  initial begin
    logic [1:0] op;
    list_len = 0;
    idle_en  = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list errors
    issue(OP_READ,   7'd0,   32'h1234_5678);
    issue(OP_DELETE, 7'd127, 32'hFFFF_FFFF);
    issue(OP_INSERT, 7'd1,   32'h0000_0001);      // past the end on empty
    // build [min, max] then append and insert in the middle
    issue(OP_INSERT, 7'd0,   32'h7FFF_FFFF);
    issue(OP_INSERT, 7'd0,   32'h8000_0000);
    issue(OP_INSERT, 7'd2,   32'hFFFF_FFFF);      // at count: append
    issue(OP_INSERT, 7'd1,   32'h0000_0000);
    issue(OP_INSERT, 7'd5,   32'h5555_5555);      // past the end
    issue(OP_READ,   7'd0,   32'h0);
    issue(OP_READ,   7'd3,   32'h0);              // last entry
    issue(OP_READ,   7'd4,   32'h0);              // at count
    issue(OP_READ,   7'd127, 32'h0);
    issue(OP_DELETE, 7'd4,   32'h0);              // at count
    issue(OP_UNUSED, 7'd5,   32'hA5A5_A5A5);
    issue(OP_DELETE, 7'd1,   32'h0);              // middle
    issue(OP_DELETE, 7'd0,   32'h0);              // head
    issue(OP_DELETE, 7'd1,   32'h0);              // tail
    issue(OP_READ,   7'd0,   32'h0);
    issue(OP_DELETE, 7'd0,   32'h0);              // back to empty
    issue(OP_DELETE, 7'd0,   32'h0);
    issue(OP_UNUSED, 7'd64,  32'h0);

    // random: alternate fill and drain spans so the list hits full and empty;
    // one span runs back to back with no idle cycles
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_en = !(n >= 500 && n < 700);
      op = pick_op(((n / 200) % 2) == 0);
      issue(op, pick_pos(op), $urandom);
    end
    start_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // catch any stray strobe
    if (mismatches == 0) begin
      $display("[positional_list_buffer] OK");
    end else begin
      $display("[positional_list_buffer] ERROR");
    end
    $finish;
  end

endmodule

>>> positional_list_buffer.f
+incdir+rtl/core
rtl/core/plb_pkg.sv
rtl/core/plb_cell.sv
rtl/core/positional_list_buffer.sv
sim/positional_list_buffer_chk.sv
sim/positional_list_buffer_tb.sv
